/* src/omd_pkg.sv */
// Shared constants and helpers for the ordered matrix dither block.
package omd_pkg;

    // Field and register widths
    localparam int PIX_W   = 8;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 2;
    localparam int ROW_W   = 12;
    localparam int HGT_W   = 13;
    localparam int MAX_FRAME_HEIGHT = 4096;

    // Output levels
    localparam logic [PIX_W-1:0] PIX_ON  = 8'd255;
    localparam logic [PIX_W-1:0] PIX_OFF = 8'd0;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_LOG2   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    // Quadrant digit from one row bit and one column bit
    function automatic logic [1:0] quad_digit(input logic rb, input logic cb);
        logic [1:0] q;
        unique case ({rb, cb})
            2'b00:   q = 2'd1;
            2'b01:   q = 2'd2;
            2'b10:   q = 2'd3;
            default: q = 2'd0;
        endcase
        return q;
    endfunction

endpackage

/* src/omd_threshold.sv */
// Threshold lookup from the recursive index matrix for one pixel position.
module omd_threshold
    import omd_pkg::*;
#(
    parameter int MAX_ORDER_LOG2 = 4,
    parameter int COL_W = 12
)
(
    input  logic [ROW_W-1:0]                         row,
    input  logic [COL_W-1:0]                         col,
    input  logic [$clog2(MAX_ORDER_LOG2+1)-1:0]      order,
    output logic [PIX_W-1:0]                         thr
);

    localparam int MAXK  = MAX_ORDER_LOG2;
    localparam int ORD_W = $clog2(MAXK + 1);
    localparam int D_W   = 2 * MAXK;
    localparam int NUM_W = D_W + 1 + PIX_W;

    logic [MAXK+ROW_W-1:0] row_x;
    logic [MAXK+COL_W-1:0] col_x;
    logic [1:0]            q     [MAXK];
    logic [D_W-1:0]        d;
    logic [D_W:0]          odd;
    logic [NUM_W-1:0]      num;
    logic [NUM_W-1:0]      thr_full;
    logic [ORD_W:0]        shamt;

    assign row_x = (MAXK + ROW_W)'(row);
    assign col_x = (MAXK + COL_W)'(col);

    // Quadrant digit for every bit position
    always_comb
    begin
        for (int b = 0; b < MAXK; b++)
        begin
            q[b] = quad_digit(row_x[b], col_x[b]);
        end
    end

    // Reverse digit order: bit k-1 lands at weight 4^0
    always_comb
    begin
        d = '0;
        for (int j = 0; j < MAXK; j++)
        begin
            for (int b = 0; b < MAXK; b++)
            begin
                if (32'(b + j + 1) == 32'(order))
                begin
                    d[2*j +: 2] = q[b];
                end
            end
        end
    end

    // floor((2d+1)*255 / 2^(2k+1))
    assign odd      = {d, 1'b1};
    assign num      = {odd, {PIX_W{1'b0}}} - NUM_W'(odd);
    assign shamt    = {order, 1'b1};
    assign thr_full = num >> shamt;
    assign thr      = thr_full[PIX_W-1:0];

endmodule

/* src/ordered_matrix_dither.sv */
// Top level of the ordered matrix dither: position counters, compare and output stage.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  input   | in_valid, in_stall, pixel_in     | in beat
//  output  | out_valid, out_stall, pixel_out  | out beat
//  config  | cfg_we, cfg_index, cfg_data      | write only
//
// One pixel per cycle while out_stall does not block; each result shows in the cycle
// after its input beat, set by the single output register after the threshold compare.
// in_stall rises only while the output register holds a beat that out_stall blocks.
// Reset clears the counters and the output valid, and loads the register defaults.
module ordered_matrix_dither
    import omd_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = 4096,
    parameter int MAX_ORDER_LOG2 = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PIX_W-1:0]     pixel_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [PIX_W-1:0]     pixel_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int ORD_W = $clog2(MAX_ORDER_LOG2 + 1);
    localparam int COL_W = $clog2(MAX_LINE_WIDTH);
    localparam int W_W   = $clog2(MAX_LINE_WIDTH + 1);
    localparam int CMP_W = W_W + 1;
    localparam int K_RST = (MAX_ORDER_LOG2 < 2) ? MAX_ORDER_LOG2 : 2;
    localparam int W_RST = (MAX_LINE_WIDTH < 750) ? MAX_LINE_WIDTH : 750;
    localparam int H_RST = 500;

    function automatic int clamp_int(input int v, input int lo, input int hi);
        int r;
        r = v;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    logic [ORD_W-1:0] order_reg;
    logic [W_W-1:0]   width_reg;
    logic [HGT_W-1:0] height_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             out_valid_reg;
    logic [PIX_W-1:0] pixel_out_reg;
    logic             in_take;
    logic             out_free;
    logic [CMP_W-1:0] col_inc;
    logic             col_wrap;
    logic [HGT_W-1:0] row_inc;
    logic             row_wrap;
    logic             row_over;
    logic [PIX_W-1:0] thr;

    // Store registers already clamped to their legal ranges
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg  <= ORD_W'(K_RST);
            width_reg  <= W_W'(W_RST);
            height_reg <= HGT_W'(H_RST);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORDER_LOG2:
                begin
                    order_reg <= ORD_W'(clamp_int(int'(cfg_data[2:0]), 1, MAX_ORDER_LOG2));
                end
                REG_LINE_WIDTH:
                begin
                    width_reg <= W_W'(clamp_int(int'(cfg_data), 1, MAX_LINE_WIDTH));
                end
                REG_FRAME_HEIGHT:
                begin
                    height_reg <= HGT_W'(clamp_int(int'(cfg_data), 1, MAX_FRAME_HEIGHT));
                end
                default:
                begin
                    order_reg <= order_reg;
                end
            endcase
        end
    end

    // Handshake: output register frees when empty or drained this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !out_free;
    assign in_take  = in_valid && out_free;

    // Advance column and row, wrapping at the configured limits
    always_comb
    begin
        col_inc  = CMP_W'(col_reg) + CMP_W'(1);
        col_wrap = col_inc >= CMP_W'(width_reg);
        row_inc  = HGT_W'(row_reg) + HGT_W'(1);
        row_wrap = row_inc >= height_reg;
        row_over = HGT_W'(row_reg) >= height_reg;
        if (col_wrap)
        begin
            col_next = '0;
            row_next = row_wrap ? '0 : row_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_over ? '0 : row_reg;
        end
    end

    omd_threshold #(
        .MAX_ORDER_LOG2 (MAX_ORDER_LOG2),
        .COL_W          (COL_W)
    ) u_thr (
        .row   (row_reg),
        .col   (col_reg),
        .order (order_reg),
        .thr   (thr)
    );

    // Hold counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid;
            end
        end
    end

    // Load the dithered pixel with each input beat
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pixel_out_reg <= (pixel_in > thr) ? PIX_ON : PIX_OFF;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;

endmodule

/* src/omd_checker.sv */
// Port-level checker for the ordered matrix dither, bound to the top level.
module omd_checker
    import omd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [PIX_W-1:0] pixel_out
);

    // A blocked output beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_out))
        else $error("output beat changed while stalled");

    // Results are only full on or full off
    a_out_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pixel_out == PIX_ON || pixel_out == PIX_OFF))
        else $error("output pixel not 0 or 255");

    // Every input beat shows up on the next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("input beat produced no output");

    // Stall the input only when the output is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a blocked output");

    // A drained output with no new beat goes empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !(in_valid && !in_stall) |=> !out_valid)
        else $error("output beat repeated");

endmodule

bind ordered_matrix_dither omd_checker u_omd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_out (pixel_out)
);
